/* hdl/xyli_pkg.sv */
package xyli_pkg;

    // Defaults for the top-level parameters
    localparam int STAGES_DEF     = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 3;
    // Signed partial sum of the serial cross product
    localparam int ACC_BITS   = FIELD_BITS + 2;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_STAGE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_APPLY,
        ST_SKIP_WAIT,
        ST_SKIP_CHK,
        ST_START_WAIT,
        ST_START_LOAD,
        ST_EMIT
    } xyli_state_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic                  limit_hit;
        logic [SLOT_BITS-1:0]  stage_slot;
        logic [FIELD_BITS-1:0] stage_pulses;
        logic [FIELD_BITS-1:0] stage_period;
        logic                  move_dir_x;
        logic                  move_dir_y;
        logic                  octant;
        logic [FIELD_BITS-1:0] pulses_x;
        logic [FIELD_BITS-1:0] pulses_y;
    } xyli_cmd_t;

    typedef struct packed {
        logic                  step_pin_x;
        logic                  step_pin_y;
        logic                  dir_pin_x;
        logic                  dir_pin_y;
        logic [FIELD_BITS-1:0] tick_period;
        logic                  period_update;
        logic                  move_busy;
        logic                  limit_stopped;
    } xyli_res_t;

endpackage

/* hdl/xyli_if.sv */
interface xyli_cmd_if;
    import xyli_pkg::*;

    logic      valid;
    logic      ready;
    xyli_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xyli_res_if;
    import xyli_pkg::*;

    logic      valid;
    logic      ready;
    xyli_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/xyli_ram.sv */
module xyli_ram #(
    parameter  int WIDTH     = 32,
    parameter  int DEPTH     = 8,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/xy_line_step_interpolator.sv */
// Channel | Dir | Handshake         | Payload
// cmd     | in  | valid/ready       | xyli_cmd_t: tick, stage write or move start
// res     | out | valid/ready       | xyli_res_t: pin levels, period, status
//
// One transaction in, one transaction out. Stage writes, plain ticks and ignored
// requests go from IDLE to EMIT; a move start waits in START_WAIT and START_LOAD
// for the stage table read. A stepping tick runs the bit-serial cross product loop
// in CROSS and APPLY, plus SKIP_WAIT and SKIP_CHK per entry examined when a stage ends.
// Reset (rst_n low, async) clears all motion state; the stage table has no reset.
// cmd is taken only in IDLE; a finished result waits in the res register while
// the next cmd transaction is accepted, and only EMIT stalls on res.ready.
module xy_line_step_interpolator #(
    parameter int STAGES     = xyli_pkg::STAGES_DEF,
    parameter int COUNT_BITS = xyli_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    xyli_cmd_if.sink      cmd,
    xyli_res_if.source    res
);
    import xyli_pkg::*;

    localparam int ADDR_BITS = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int IDX_BITS  = $clog2(STAGES + 1);
    localparam int BIT_BITS  = $clog2(COUNT_BITS);
    localparam int CMP_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam int ENT_BITS  = 2 * FIELD_BITS;

    // Sequencer and motion state
    xyli_state_t            state_reg,       state_next;
    logic [COUNT_BITS-1:0]  count_x_reg,     count_x_next;
    logic [COUNT_BITS-1:0]  count_y_reg,     count_y_next;
    logic [FIELD_BITS-1:0]  stage_count_reg, stage_count_next;
    logic [IDX_BITS-1:0]    stage_index_reg, stage_index_next;
    logic                   busy_reg,        busy_next;
    logic                   halted_reg,      halted_next;
    logic                   pend_x_reg,      pend_x_next;
    logic                   pend_y_reg,      pend_y_next;
    logic [1:0]             pin_reg,         pin_next;
    logic [1:0]             dir_reg,         dir_next;
    logic                   oct_reg,         oct_next;
    logic [FIELD_BITS-1:0]  total_x_reg,     total_x_next;
    logic [FIELD_BITS-1:0]  total_y_reg,     total_y_next;
    logic [FIELD_BITS-1:0]  period_reg,      period_next;
    logic                   loaded_reg,      loaded_next;

    // Bit-serial cross product: count copies shift out LSB first
    logic [COUNT_BITS-1:0]  sx_reg,          sx_next;
    logic [COUNT_BITS-1:0]  sy_reg,          sy_next;
    logic signed [ACC_BITS-1:0] acc_reg,     acc_next;
    logic [BIT_BITS-1:0]    bit_reg,         bit_next;

    // Result register
    logic                   res_valid_reg,   res_valid_next;
    xyli_res_t              res_data_reg,    res_data_next;

    // Stage table
    logic                   ram_we;
    logic [ENT_BITS-1:0]    ram_rdata;
    logic [FIELD_BITS-1:0]  rd_pulses;
    logic [FIELD_BITS-1:0]  rd_period;

    // Datapath helpers
    logic signed [ACC_BITS-1:0] term_pos;
    logic signed [ACC_BITS-1:0] term_neg;
    logic signed [ACC_BITS-1:0] acc_sum;
    logic                   f_neg;
    logic                   step_x;
    logic                   step_y;
    logic [COUNT_BITS-1:0]  cx_new;
    logic [COUNT_BITS-1:0]  cy_new;
    logic [FIELD_BITS-1:0]  sc_inc;
    logic                   dom_done;

    xyli_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (STAGES)
    ) u_stage_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_BITS'(cmd.data.stage_slot)),
        .wdata ({cmd.data.stage_pulses, cmd.data.stage_period}),
        .raddr (stage_index_reg[ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_pulses = ram_rdata[ENT_BITS-1:FIELD_BITS];
    assign rd_period = ram_rdata[FIELD_BITS-1:0];

    // acc' = (acc + cy[b]*NX - cx[b]*NY) >>> 1; the dropped LSBs are nonnegative,
    // so the final acc carries the sign of the full product difference.
    assign term_pos = sy_reg[0] ? $signed({2'b00, total_x_reg}) : '0;
    assign term_neg = sx_reg[0] ? $signed({2'b00, total_y_reg}) : '0;
    assign acc_sum  = acc_reg + term_pos - term_neg;

    assign f_neg  = acc_reg[ACC_BITS-1];
    assign step_x = oct_reg ? !f_neg : 1'b1;
    assign step_y = oct_reg ? 1'b1 : f_neg;
    assign cx_new = step_x ? count_x_reg + 1'b1 : count_x_reg;
    assign cy_new = step_y ? count_y_reg + 1'b1 : count_y_reg;
    assign sc_inc = stage_count_reg + 1'b1;

    // End of move once the dominant axis reaches its total
    assign dom_done = oct_reg ? (CMP_BITS'(cy_new) >= CMP_BITS'(total_y_reg))
                              : (CMP_BITS'(cx_new) >= CMP_BITS'(total_x_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_x_reg     <= '0;
            count_y_reg     <= '0;
            stage_count_reg <= '0;
            stage_index_reg <= '0;
            busy_reg        <= 1'b0;
            halted_reg      <= 1'b0;
            pend_x_reg      <= 1'b0;
            pend_y_reg      <= 1'b0;
            pin_reg         <= '0;
            dir_reg         <= '0;
            oct_reg         <= 1'b0;
            total_x_reg     <= '0;
            total_y_reg     <= '0;
            period_reg      <= '0;
            loaded_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_x_reg     <= count_x_next;
            count_y_reg     <= count_y_next;
            stage_count_reg <= stage_count_next;
            stage_index_reg <= stage_index_next;
            busy_reg        <= busy_next;
            halted_reg      <= halted_next;
            pend_x_reg      <= pend_x_next;
            pend_y_reg      <= pend_y_next;
            pin_reg         <= pin_next;
            dir_reg         <= dir_next;
            oct_reg         <= oct_next;
            total_x_reg     <= total_x_next;
            total_y_reg     <= total_y_next;
            period_reg      <= period_next;
            loaded_reg      <= loaded_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        acc_reg      <= acc_next;
        bit_reg      <= bit_next;
        res_data_reg <= res_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_x_next     = count_x_reg;
        count_y_next     = count_y_reg;
        stage_count_next = stage_count_reg;
        stage_index_next = stage_index_reg;
        busy_next        = busy_reg;
        halted_next      = halted_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pin_next         = pin_reg;
        dir_next         = dir_reg;
        oct_next         = oct_reg;
        total_x_next     = total_x_reg;
        total_y_next     = total_y_reg;
        period_next      = period_reg;
        loaded_next      = loaded_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        acc_next         = acc_reg;
        bit_next         = bit_reg;
        res_data_next    = res_data_reg;
        res_valid_next   = res_valid_reg;
        ram_we           = 1'b0;

        cmd.ready = (state_reg == ST_IDLE);

        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    loaded_next = 1'b0;
                    state_next  = ST_EMIT;
                    case (cmd.data.req_type)
                        REQ_STAGE:
                        begin
                            if (int'(cmd.data.stage_slot) < STAGES)
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        REQ_START:
                        begin
                            if (!busy_reg)
                            begin
                                if (halted_reg)
                                begin
                                    halted_next = 1'b0;
                                    pend_x_next = 1'b0;
                                    pend_y_next = 1'b0;
                                end
                                dir_next         = {cmd.data.move_dir_y, cmd.data.move_dir_x};
                                oct_next         = cmd.data.octant;
                                total_x_next     = cmd.data.pulses_x;
                                total_y_next     = cmd.data.pulses_y;
                                busy_next        = 1'b1;
                                stage_index_next = '0;
                                stage_count_next = '0;
                                count_x_next     = '0;
                                count_y_next     = '0;
                                state_next       = ST_START_WAIT;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (!halted_reg)
                            begin
                                if (cmd.data.limit_hit)
                                begin
                                    // limit stop keeps pin levels
                                    halted_next      = 1'b1;
                                    busy_next        = 1'b0;
                                    count_x_next     = '0;
                                    count_y_next     = '0;
                                    stage_count_next = '0;
                                    stage_index_next = '0;
                                end
                                else if (pend_x_reg || pend_y_reg)
                                begin
                                    // finish the pulses from the last tick
                                    pin_next    = pin_reg ^ {pend_y_reg, pend_x_reg};
                                    pend_x_next = 1'b0;
                                    pend_y_next = 1'b0;
                                end
                                else if (busy_reg)
                                begin
                                    sx_next    = count_x_reg;
                                    sy_next    = count_y_reg;
                                    acc_next   = '0;
                                    bit_next   = '0;
                                    state_next = ST_CROSS;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_START_WAIT:
            begin
                state_next = ST_START_LOAD;
            end

            ST_START_LOAD:
            begin
                period_next = rd_period;
                loaded_next = 1'b1;
                state_next  = ST_EMIT;
            end

            ST_CROSS:
            begin
                acc_next = acc_sum >>> 1;
                sx_next  = sx_reg >> 1;
                sy_next  = sy_reg >> 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_BITS'(COUNT_BITS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                // table entry of the current stage has been on the read port all along
                if (step_x)
                begin
                    pin_next[0] = 1'b0;
                    pend_x_next = 1'b1;
                end
                if (step_y)
                begin
                    pin_next[1] = 1'b0;
                    pend_y_next = 1'b1;
                end
                count_x_next = cx_new;
                count_y_next = cy_new;
                if (sc_inc >= rd_pulses)
                begin
                    stage_count_next = '0;
                    stage_index_next = stage_index_reg + 1'b1;
                    state_next       = ST_SKIP_WAIT;
                end
                else
                begin
                    stage_count_next = sc_inc;
                    state_next       = ST_EMIT;
                end
                if (dom_done)
                begin
                    busy_next = 1'b0;
                end
            end

            ST_SKIP_WAIT:
            begin
                // bound first, then read
                if (int'(stage_index_reg) >= STAGES)
                begin
                    busy_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SKIP_CHK;
                end
            end

            ST_SKIP_CHK:
            begin
                if (rd_pulses == '0)
                begin
                    stage_index_next = stage_index_reg + 1'b1;
                    state_next       = ST_SKIP_WAIT;
                end
                else
                begin
                    period_next = rd_period;
                    loaded_next = 1'b1;
                    state_next  = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next              = 1'b1;
                    res_data_next.step_pin_x    = pin_reg[0];
                    res_data_next.step_pin_y    = pin_reg[1];
                    res_data_next.dir_pin_x     = dir_reg[0];
                    res_data_next.dir_pin_y     = dir_reg[1];
                    res_data_next.tick_period   = period_reg;
                    res_data_next.period_update = loaded_reg;
                    res_data_next.move_busy     = busy_reg;
                    res_data_next.limit_stopped = halted_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

endmodule

/* sim/tb_xy_line_step_interpolator.sv */
`timescale 1ns / 1ps

module tb_xy_line_step_interpolator;
    import xyli_pkg::*;

    // Request code the block must ignore (not defined in the package)
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam int ITEMS     = 1050;   // total cmd transactions to send
    localparam int HOLD_OFF  = 300;    // long res stall to back up the block
    localparam int DRAIN_CYC = 64;     // above the slowest tick, stage skips included

    // ------------------------------------------------------------------
    // Motion predictor: mirrors the interpolator state, predicts one status
    // transaction per accepted cmd, and checks the observed ones in order.
    // ------------------------------------------------------------------
    class step_motion_checker;
        bit [COUNT_BITS_DEF-1:0] x_steps, y_steps;
        bit [FIELD_BITS-1:0]     steps_in_stage;
        int unsigned             stage_at;
        bit                      moving, stopped, x_pulse_open, y_pulse_open;
        bit [1:0]                pins, dirs;
        bit                      y_major;
        bit [FIELD_BITS-1:0]     x_total, y_total, period;
        bit [FIELD_BITS-1:0]     pulse_tab  [STAGES_DEF];
        bit [FIELD_BITS-1:0]     period_tab [STAGES_DEF];
        xyli_res_t               status_due [$];
        int                      mismatch_count;

        // one step on the chosen axes: pin goes low, pulse stays open
        function void emit_step(bit sx, bit sy);
            if (sx)
            begin
                pins[0]      = 1'b0;
                x_steps++;
                x_pulse_open = 1'b1;
            end
            if (sy)
            begin
                pins[1]      = 1'b0;
                y_steps++;
                y_pulse_open = 1'b1;
            end
            steps_in_stage++;
        endfunction

        function void accept_cmd(xyli_cmd_t c);
            bit        loaded;
            longint    err_term;
            xyli_res_t r;
            loaded = 1'b0;
            case (c.req_type)
                REQ_STAGE:
                begin
                    pulse_tab[c.stage_slot]  = c.stage_pulses;
                    period_tab[c.stage_slot] = c.stage_period;
                end
                REQ_START:
                begin
                    if (!moving)
                    begin
                        if (stopped)
                        begin
                            stopped      = 1'b0;
                            x_pulse_open = 1'b0;
                            y_pulse_open = 1'b0;
                        end
                        dirs           = {c.move_dir_y, c.move_dir_x};
                        y_major        = c.octant;
                        x_total        = c.pulses_x;
                        y_total        = c.pulses_y;
                        period         = period_tab[0];
                        loaded         = 1'b1;
                        moving         = 1'b1;
                        stage_at       = 0;
                        steps_in_stage = '0;
                        x_steps        = '0;
                        y_steps        = '0;
                    end
                end
                REQ_TICK:
                begin
                    if (!stopped)
                    begin
                        if (c.limit_hit)
                        begin
                            stopped        = 1'b1;
                            moving         = 1'b0;
                            x_steps        = '0;
                            y_steps        = '0;
                            steps_in_stage = '0;
                            stage_at       = 0;
                        end
                        else if (x_pulse_open || y_pulse_open)
                        begin
                            if (x_pulse_open) pins[0] = ~pins[0];
                            if (y_pulse_open) pins[1] = ~pins[1];
                            x_pulse_open = 1'b0;
                            y_pulse_open = 1'b0;
                        end
                        else if (moving)
                        begin
                            // sign of the line error decides the minor axis step
                            err_term = longint'(x_total) * longint'(y_steps)
                                     - longint'(y_total) * longint'(x_steps);
                            if (!y_major)
                                emit_step(1'b1, err_term < 0);
                            else
                                emit_step(err_term >= 0, 1'b1);

                            if (steps_in_stage >= pulse_tab[stage_at])
                            begin
                                steps_in_stage = '0;
                                stage_at++;
                                while (stage_at < STAGES_DEF && pulse_tab[stage_at] == 0)
                                    stage_at++;
                                if (stage_at >= STAGES_DEF)
                                    moving = 1'b0;
                                else
                                begin
                                    period = period_tab[stage_at];
                                    loaded = 1'b1;
                                end
                            end
                            if (!y_major && x_steps >= x_total) moving = 1'b0;
                            if (y_major && y_steps >= y_total)  moving = 1'b0;
                        end
                    end
                end
                default: ;
            endcase

            r.step_pin_x    = pins[0];
            r.step_pin_y    = pins[1];
            r.dir_pin_x     = dirs[0];
            r.dir_pin_y     = dirs[1];
            r.tick_period   = period;
            r.period_update = loaded;
            r.move_busy     = moving;
            r.limit_stopped = stopped;
            status_due.push_back(r);
        endfunction

        function void check_field(string name, bit [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_status(xyli_res_t got);
            xyli_res_t want;
            if (status_due.size() == 0)
            begin
                $error("status transaction with nothing pending: %0h", got);
                mismatch_count++;
                return;
            end
            want = status_due.pop_front();
            check_field("step_pin_x",    16'(want.step_pin_x),    16'(got.step_pin_x));
            check_field("step_pin_y",    16'(want.step_pin_y),    16'(got.step_pin_y));
            check_field("dir_pin_x",     16'(want.dir_pin_x),     16'(got.dir_pin_x));
            check_field("dir_pin_y",     16'(want.dir_pin_y),     16'(got.dir_pin_y));
            check_field("tick_period",   want.tick_period,        got.tick_period);
            check_field("period_update", 16'(want.period_update), 16'(got.period_update));
            check_field("move_busy",     16'(want.move_busy),     16'(got.move_busy));
            check_field("limit_stopped", 16'(want.limit_stopped), 16'(got.limit_stopped));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    xyli_cmd_if cmd_if ();
    xyli_res_if res_if ();

    xy_line_step_interpolator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    step_motion_checker motion = new();

    // Traffic shaping, written by the stimulus, read by the res process
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int sent_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb_xy_line_step_interpolator failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // cmd side
    // ------------------------------------------------------------------

    // All fields random, so don't-care bits toggle too
    function automatic xyli_cmd_t rand_cmd();
        xyli_cmd_t c;
        c.req_type     = 2'($urandom_range(3));
        c.limit_hit    = 1'($urandom_range(1));
        c.stage_slot   = 3'($urandom_range(7));
        c.stage_pulses = 16'($urandom);
        c.stage_period = 16'($urandom);
        c.move_dir_x   = 1'($urandom_range(1));
        c.move_dir_y   = 1'($urandom_range(1));
        c.octant       = 1'($urandom_range(1));
        c.pulses_x     = 16'($urandom);
        c.pulses_y     = 16'($urandom);
        return c;
    endfunction

    function automatic xyli_cmd_t mk_tick(bit lim);
        xyli_cmd_t c;
        c           = rand_cmd();
        c.req_type  = REQ_TICK;
        c.limit_hit = lim;
        return c;
    endfunction

    function automatic xyli_cmd_t mk_stage(int slot, bit [15:0] p, bit [15:0] per);
        xyli_cmd_t c;
        c              = rand_cmd();
        c.req_type     = REQ_STAGE;
        c.stage_slot   = 3'(slot);
        c.stage_pulses = p;
        c.stage_period = per;
        return c;
    endfunction

    function automatic xyli_cmd_t mk_start(bit dx, bit dy, bit oct,
                                           bit [15:0] px, bit [15:0] py);
        xyli_cmd_t c;
        c            = rand_cmd();
        c.req_type   = REQ_START;
        c.move_dir_x = dx;
        c.move_dir_y = dy;
        c.octant     = oct;
        c.pulses_x   = px;
        c.pulses_y   = py;
        return c;
    endfunction

    function automatic xyli_cmd_t mk_other();
        xyli_cmd_t c;
        c          = rand_cmd();
        c.req_type = REQ_NONE;
        return c;
    endfunction

    // Mostly short stages, some skipped, now and then a huge one
    function automatic xyli_cmd_t rand_stage();
        int        pick;
        bit [15:0] p;
        pick = $urandom_range(99);
        if (pick < 40)
            p = '0;
        else if (pick < 90)
            p = 16'($urandom_range(1, 4));
        else
            p = 16'($urandom);
        return mk_stage($urandom_range(7), p, 16'($urandom));
    endfunction

    // Called at a rising edge; returns at the edge where the transaction went in.
    // valid is only dropped when an idle gap follows, never toggled in one step.
    task automatic send_cmd(input xyli_cmd_t c);
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        motion.accept_cmd(c);
        sent_count++;
    endtask

    // One well-formed move: optional stage edits, start, ticks until it ends,
    // with sparse noise; an overlong move is cut by a limit tick.
    task automatic run_move();
        bit [15:0] major, minor;
        bit        oct;
        int        n_ticks;
        int        pick;
        if ($urandom_range(1))
            repeat ($urandom_range(1, 3)) send_cmd(rand_stage());
        if ($urandom_range(99) < 85)
        begin
            major = 16'($urandom_range(24));
            minor = 16'($urandom_range(major));
        end
        else
        begin
            major = 16'($urandom);
            minor = 16'($urandom);
        end
        oct = 1'($urandom_range(1));
        send_cmd(mk_start(1'($urandom_range(1)), 1'($urandom_range(1)), oct,
                          oct ? minor : major, oct ? major : minor));
        n_ticks = $urandom_range(10, 70);
        for (int i = 0; i < n_ticks; i++)
        begin
            if (motion.stopped ||
                (!motion.moving && !motion.x_pulse_open && !motion.y_pulse_open))
                break;
            pick = $urandom_range(99);
            if (pick < 2)
                send_cmd(mk_tick(1'b1));
            else if (pick < 3)
                send_cmd(rand_stage());
            else if (pick < 4)
                send_cmd(mk_start(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 16'($urandom), 16'($urandom)));
            else if (pick < 5)
                send_cmd(mk_other());
            else
                send_cmd(mk_tick(1'b0));
        end
        if (motion.moving)
            send_cmd(mk_tick(1'b1));
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        send_cmd(mk_other());                       // unknown request
        send_cmd(mk_tick(1'b0));                    // tick with nothing to do
        // every entry written before any start so no stale entry is read
        send_cmd(mk_stage(0, 16'd1, 16'hFFFF));
        send_cmd(mk_stage(1, 16'd0, 16'h0000));     // skipped stage
        send_cmd(mk_stage(2, 16'd2, 16'h1234));
        for (int s = 3; s < 7; s++)
            send_cmd(mk_stage(s, 16'd0, 16'h00FF));
        send_cmd(mk_stage(7, 16'hFFFF, 16'h8000));
        // Y-dominant move with extreme totals: walks stage 0 -> 2 -> 7
        send_cmd(mk_start(1'b0, 1'b1, 1'b1, 16'd1, 16'hFFFF));
        repeat (6) send_cmd(mk_tick(1'b0));
        send_cmd(mk_start(1'b1, 1'b0, 1'b0, 16'd5, 16'd5));  // start while busy
        send_cmd(mk_tick(1'b1));                    // limit stop
        send_cmd(mk_tick(1'b0));                    // tick while stopped
        // restart after stop, zero dominant total: one step then done
        send_cmd(mk_start(1'b0, 1'b0, 1'b0, 16'd0, 16'd0));
        send_cmd(mk_tick(1'b0));
        send_cmd(mk_tick(1'b0));                    // pin returns high while idle

        // ---- random, four traffic phases ----
        hold_req = HOLD_OFF;                        // back up the block once
        while (sent_count < ITEMS)
        begin
            case (sent_count * 4 / ITEMS)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            if ($urandom_range(99) < 85)
                run_move();
            else
                send_cmd(rand_cmd());
        end
        cmd_if.valid <= 1'b0;

        // drain: wait for outstanding status, then a safety margin
        while (motion.status_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (motion.status_due.size() != 0)
        begin
            $error("%0d status transactions never arrived", motion.status_due.size());
            motion.mismatch_count++;
        end
        if (motion.mismatch_count == 0)
            $display("tb_xy_line_step_interpolator passed");
        else
            $display("tb_xy_line_step_interpolator failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // res side: random stalls, plus one long hold-off counted here
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                motion.check_status(res_if.data);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

endmodule

/* filelist.f */
hdl/xyli_pkg.sv
hdl/xyli_if.sv
hdl/xyli_ram.sv
hdl/xy_line_step_interpolator.sv
sim/tb_xy_line_step_interpolator.sv
